>>> hw/rtl/segment_intersection_test_defines.svh
// Assertion macros for the segment intersection test block.
// Included by the top level; depends on nothing.
`ifndef SEGMENT_INTERSECTION_TEST_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SIT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SIT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sit_pkg.sv
// Shared types for the segment intersection test block.
// Used by sit_orient and segment_intersection_test; depends on nothing.
package sit_pkg;

  localparam int unsigned CLASS_BITS = 3;
  localparam int unsigned OUT_BITS   = 16;

  typedef enum logic [CLASS_BITS-1:0] {
    CLS_CCW    = 3'd0,
    CLS_CW     = 3'd1,
    CLS_BEHIND = 3'd2,
    CLS_BEYOND = 3'd3,
    CLS_ON     = 3'd4
  } class_t;

  // Sign of the signed code that a class stands for.
  function automatic logic class_pos(class_t c);
    return (c == CLS_CCW) || (c == CLS_BEHIND);
  endfunction

  function automatic logic class_neg(class_t c);
    return (c == CLS_CW) || (c == CLS_BEYOND);
  endfunction

endpackage

>>> hw/rtl/sit_orient.sv
// Orientation class of point c against directed segment a->b, two pipeline stages.
// Depends on sit_pkg; class output is combinational from the product registers.
module sit_orient import sit_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  output class_t                       cls
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned XW = PW + 1;

  logic signed [DW-1:0] ux, uy, vx, vy;
  logic signed [PW-1:0] ux_vy, uy_vx, ux_vx, uy_vy, ux_ux, uy_uy, vx_vx, vy_vy;
  logic signed [XW-1:0] cross_prod, dot, len_u, len_v;

  always_ff @(posedge clk) begin
    if (en) begin
      ux <= DW'(bx) - DW'(ax);
      uy <= DW'(by) - DW'(ay);
      vx <= DW'(cx) - DW'(ax);
      vy <= DW'(cy) - DW'(ay);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux_vy <= PW'(ux) * PW'(vy);
      uy_vx <= PW'(uy) * PW'(vx);
      ux_vx <= PW'(ux) * PW'(vx);
      uy_vy <= PW'(uy) * PW'(vy);
      ux_ux <= PW'(ux) * PW'(ux);
      uy_uy <= PW'(uy) * PW'(uy);
      vx_vx <= PW'(vx) * PW'(vx);
      vy_vy <= PW'(vy) * PW'(vy);
    end
  end

  always_comb begin
    cross_prod = XW'(ux_vy) - XW'(uy_vx);
    dot        = XW'(ux_vx) + XW'(uy_vy);
    len_u      = XW'(ux_ux) + XW'(uy_uy);
    len_v      = XW'(vx_vx) + XW'(vy_vy);
    priority if (cross_prod > 0) begin
      cls = CLS_CCW;
    end else if (cross_prod < 0) begin
      cls = CLS_CW;
    end else if (dot < 0) begin
      cls = CLS_BEHIND;
    end else if (len_u < len_v) begin
      // farther from the start than the end is; also any point off a degenerate segment
      cls = CLS_BEYOND;
    end else begin
      cls = CLS_ON;
    end
  end

endmodule

>>> hw/rtl/segment_intersection_test.sv
// Segment intersection test: four orientation classes and a meet flag per segment pair.
// Top level; depends on sit_pkg, sit_orient and segment_intersection_test_defines.svh.
//
// Usage:
//   Input channel s_axis carries one segment pair per item: eight signed
//   coordinates of COORD_BITS each (seg1 start, seg1 end, seg2 start, seg2 end).
//   Output channel m_axis carries one result per item: the meet flag and the
//   class of each endpoint against the other segment.
// Path from input acceptance to m_axis_tvalid: input register, difference register,
//   product register, result register.
// Throughput: one item per cycle unless m_axis stalls, set by the single pass through the four
//   parallel orientation units, each with eight multipliers.
// Stall: all stages advance together while the result register is empty or
//   being taken; when the receiver holds tready low with a result waiting,
//   the whole pipeline holds and s_axis_tready drops.
// Reset: rst clears all stage valid flags; no result is pending after reset.
`include "segment_intersection_test_defines.svh"

module segment_intersection_test import sit_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // low to high: seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
  //              seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y
  input  logic [8*COORD_BITS-1:0]   s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // low to high: segments_meet, seg2_start_class, seg2_end_class,
  //              seg1_start_class, seg1_end_class, 3 zero bits
  output logic [OUT_BITS-1:0]       m_axis_tdata
);

  localparam int unsigned CB = COORD_BITS;

  logic signed [CB-1:0] p0x, p0y, p1x, p1y, q0x, q0y, q1x, q1y;
  logic                 v_in, v_diff, v_prod;
  logic                 advance;
  class_t               a0, a1, b0, b1;
  logic                 meet;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in          <= 1'b0;
      v_diff        <= 1'b0;
      v_prod        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      v_in          <= s_axis_tvalid;
      v_diff        <= v_in;
      v_prod        <= v_diff;
      m_axis_tvalid <= v_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p0x <= s_axis_tdata[0*CB +: CB];
      p0y <= s_axis_tdata[1*CB +: CB];
      p1x <= s_axis_tdata[2*CB +: CB];
      p1y <= s_axis_tdata[3*CB +: CB];
      q0x <= s_axis_tdata[4*CB +: CB];
      q0y <= s_axis_tdata[5*CB +: CB];
      q1x <= s_axis_tdata[6*CB +: CB];
      q1y <= s_axis_tdata[7*CB +: CB];
    end
  end

  sit_orient #(.COORD_BITS(COORD_BITS)) u_a0 (
    .clk(clk), .en(advance),
    .ax(p0x), .ay(p0y), .bx(p1x), .by(p1y), .cx(q0x), .cy(q0y), .cls(a0)
  );
  sit_orient #(.COORD_BITS(COORD_BITS)) u_a1 (
    .clk(clk), .en(advance),
    .ax(p0x), .ay(p0y), .bx(p1x), .by(p1y), .cx(q1x), .cy(q1y), .cls(a1)
  );
  sit_orient #(.COORD_BITS(COORD_BITS)) u_b0 (
    .clk(clk), .en(advance),
    .ax(q0x), .ay(q0y), .bx(q1x), .by(q1y), .cx(p0x), .cy(p0y), .cls(b0)
  );
  sit_orient #(.COORD_BITS(COORD_BITS)) u_b1 (
    .clk(clk), .en(advance),
    .ax(q0x), .ay(q0y), .bx(q1x), .by(q1y), .cx(p1x), .cy(p1y), .cls(b1)
  );

  // Drop the meet flag when both endpoints of one segment share a sign: CCW or behind, or CW or beyond.
  always_comb begin
    meet = !((class_pos(a0) && class_pos(a1)) || (class_neg(a0) && class_neg(a1))) &&
           !((class_pos(b0) && class_pos(b1)) || (class_neg(b0) && class_neg(b1)));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {3'b000, b1, b0, a1, a0, meet};
    end
  end

  `SIT_ASSERT_NEXT(a_accept_enters, clk, rst, s_axis_tvalid && s_axis_tready, v_in,
    "accepted item did not enter the input stage")
  `SIT_ASSERT_NEXT(a_prod_to_out, clk, rst, v_prod && advance, m_axis_tvalid,
    "product stage item did not reach the result register")
  `SIT_ASSERT_NOW(a_meet_sides, clk, rst, m_axis_tvalid && m_axis_tdata[0],
    !((m_axis_tdata[3:1] == CLS_CCW) && (m_axis_tdata[6:4] == CLS_CCW)) &&
    !((m_axis_tdata[9:7] == CLS_CW) && (m_axis_tdata[12:10] == CLS_CW)),
    "meet flag set with endpoints strictly on one side")
  `SIT_ASSERT_NOW(a_class_range, clk, rst, m_axis_tvalid,
    (m_axis_tdata[3:1] <= CLS_ON) && (m_axis_tdata[6:4] <= CLS_ON) &&
    (m_axis_tdata[9:7] <= CLS_ON) && (m_axis_tdata[12:10] <= CLS_ON),
    "class code out of range")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for segment_intersection_test: random and directed segment pairs
// over the stream ports, each result compared against an exact integer orientation model.
// Depends on sit_pkg and the segment_intersection_test RTL.

module testbench;
  import sit_pkg::*;

  localparam int unsigned COORD_BITS  = 16;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RAND_PAIRS  = 2000;

  // First field in the lowest bits, so seg1 start x is declared last.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] q1y;
    logic signed [COORD_BITS-1:0] q1x;
    logic signed [COORD_BITS-1:0] q0y;
    logic signed [COORD_BITS-1:0] q0x;
    logic signed [COORD_BITS-1:0] p1y;
    logic signed [COORD_BITS-1:0] p1x;
    logic signed [COORD_BITS-1:0] p0y;
    logic signed [COORD_BITS-1:0] p0x;
  } seg_pair_t;

  // Classes in output order: seg2 start, seg2 end, seg1 start, seg1 end.
  typedef struct {
    logic   meet;
    class_t cls [4];
  } meet_result_t;

  class segment_scoreboard;
    meet_result_t pending_results [$];
    int unsigned  mismatches;
    int unsigned  results_seen;

    // Orientation of point c against the directed segment a->b, exact in 64 bits.
    function class_t classify(longint ax, longint ay, longint bx, longint by,
                              longint cx, longint cy);
      longint ux, uy, vx, vy, cross_prod;
      ux = bx - ax;
      uy = by - ay;
      vx = cx - ax;
      vy = cy - ay;
      cross_prod = ux * vy - uy * vx;
      if (cross_prod > 0) return CLS_CCW;
      if (cross_prod < 0) return CLS_CW;
      if (ux * vx + uy * vy < 0) return CLS_BEHIND;
      if (ux * ux + uy * uy < vx * vx + vy * vy) return CLS_BEYOND;
      return CLS_ON;
    endfunction

    function int code_sign(class_t c);
      case (c)
        CLS_CCW, CLS_BEHIND: return 1;
        CLS_CW, CLS_BEYOND:  return -1;
        default:             return 0;
      endcase
    endfunction

    function void note_pair(seg_pair_t p);
      meet_result_t r;
      r.cls[0] = classify(p.p0x, p.p0y, p.p1x, p.p1y, p.q0x, p.q0y);
      r.cls[1] = classify(p.p0x, p.p0y, p.p1x, p.p1y, p.q1x, p.q1y);
      r.cls[2] = classify(p.q0x, p.q0y, p.q1x, p.q1y, p.p0x, p.p0y);
      r.cls[3] = classify(p.q0x, p.q0y, p.q1x, p.q1y, p.p1x, p.p1y);
      // Disjoint when both ends of one segment have the same nonzero sign code.
      r.meet = (code_sign(r.cls[0]) * code_sign(r.cls[1]) <= 0) &&
               (code_sign(r.cls[2]) * code_sign(r.cls[3]) <= 0);
      pending_results.insert(pending_results.size(), r);
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(logic [OUT_BITS-1:0] word);
      meet_result_t want;
      logic [CLASS_BITS-1:0] got;
      string names [4] = '{"seg2_start_class", "seg2_end_class",
                           "seg1_start_class", "seg1_end_class"};
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with none expected: %h",
                                  results_seen, word));
        return;
      end
      want = pending_results.pop_front();
      if (word[0] !== want.meet)
        report_mismatch($sformatf("result %0d segments_meet got %b expected %b",
                                  results_seen, word[0], want.meet));
      for (int i = 0; i < 4; i++) begin
        got = word[1 + CLASS_BITS * i +: CLASS_BITS];
        if (got !== want.cls[i])
          report_mismatch($sformatf("result %0d %s got %0d expected %0d (%s)",
                                    results_seen, names[i], got, want.cls[i],
                                    want.cls[i].name()));
      end
      if (word[OUT_BITS-1:13] !== '0)
        report_mismatch($sformatf("result %0d padding bits not zero: %b",
                                  results_seen, word[OUT_BITS-1:13]));
    endtask
  endclass

  logic                    clk;
  logic                    rst;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [8*COORD_BITS-1:0] s_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [OUT_BITS-1:0]     m_axis_tdata;

  segment_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_request;
  bit          hold_done;
  int unsigned quiet_cycles;

  segment_intersection_test #(.COORD_BITS(COORD_BITS)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one pair, maybe after an idle burst, and hold it until taken.
  task automatic send_pair(seg_pair_t p);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 18) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_pair(p);
  endtask

  task automatic send_coords(int p0x, int p0y, int p1x, int p1y,
                             int q0x, int q0y, int q1x, int q1y);
    seg_pair_t p;
    p.p0x = p0x[COORD_BITS-1:0];
    p.p0y = p0y[COORD_BITS-1:0];
    p.p1x = p1x[COORD_BITS-1:0];
    p.p1y = p1y[COORD_BITS-1:0];
    p.q0x = q0x[COORD_BITS-1:0];
    p.q0y = q0y[COORD_BITS-1:0];
    p.q1x = q1x[COORD_BITS-1:0];
    p.q1y = q1y[COORD_BITS-1:0];
    send_pair(p);
  endtask

  function automatic int edge_coord();
    case ($urandom_range(0, 6))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return 32766;
      default: return 32767;
    endcase
  endfunction

  // Mix of wild pairs with pairs built to hit collinear and touching cases.
  task automatic send_random_pair();
    seg_pair_t p;
    int c [8];
    int pick, bx, by, dx, dy;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      p = {$urandom, $urandom, $urandom, $urandom};
      send_pair(p);
      return;
    end
    bx = $urandom_range(0, 2000) - 1000;
    by = $urandom_range(0, 2000) - 1000;
    dx = $urandom_range(0, 16) - 8;
    dy = $urandom_range(0, 16) - 8;
    for (int i = 0; i < 8; i++) begin
      if (pick < 55)
        c[i] = $urandom_range(0, 8) - 4;
      else if (pick < 75)
        c[i] = (i % 2 == 0) ? bx + ($urandom_range(0, 12) - 6) * dx : 0;
      else if (pick < 85)
        c[i] = $urandom_range(0, 65535) - 32768;
      else if (pick < 95)
        c[i] = edge_coord();
      else
        c[i] = $urandom_range(0, 512) - 256;
    end
    // Collinear: keep y on the same line as x, using the step index implied by x.
    if (pick >= 55 && pick < 75)
      for (int i = 0; i < 8; i += 2)
        c[i+1] = (dx != 0) ? by + ((c[i] - bx) / dx) * dy
                           : by + ($urandom_range(0, 12) - 6) * dy;
    // Shared endpoints and degenerate segments.
    if (pick >= 75 && pick < 85)
      case ($urandom_range(0, 4))
        0: begin c[4] = c[0]; c[5] = c[1]; end
        1: begin c[4] = c[2]; c[5] = c[3]; end
        2: begin c[6] = c[2]; c[7] = c[3]; end
        3: begin c[2] = c[0]; c[3] = c[1]; end
        default: begin c[6] = c[4]; c[7] = c[5]; end
      endcase
    send_coords(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int unsigned stall_left;
    m_axis_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        stall_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        stall_left = $urandom_range(1, 18) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata);
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    send_idle_pct = 10;
    recv_idle_pct = 10;
    hold_request = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_coords(0, 0, 10, 10, 0, 10, 10, 0);          // proper crossing
    send_coords(0, 0, 10, 0, 0, 5, 10, 5);            // parallel apart
    send_coords(0, 0, 10, 0, 5, 0, 15, 0);            // collinear overlap
    send_coords(0, 0, 4, 0, 6, 0, 9, 0);              // collinear past the end
    send_coords(0, 0, 4, 0, -9, 0, -6, 0);            // collinear behind the start
    send_coords(0, 0, -3, 0, 0, 0, 4, 0);             // touching at the start
    send_coords(0, 0, 4, 4, 4, 4, 8, 0);              // shared endpoint
    send_coords(0, 0, 10, 0, 5, 0, 5, 7);             // T junction
    send_coords(0, 0, 10, 0, 5, 1, 5, 7);             // near miss
    send_coords(0, 3, 9, 8, 0, 0, 10, 0);             // one side entirely
    send_coords(3, 3, 3, 3, 0, 0, 6, 6);              // point on a segment
    send_coords(3, 4, 3, 4, 0, 0, 6, 6);              // point off a segment
    send_coords(7, -7, 7, -7, 7, -7, 7, -7);          // two equal points
    send_coords(1, 1, 1, 1, 2, 2, 2, 2);              // two distinct points
    send_coords(2, 3, 8, 9, 2, 3, 8, 9);              // identical segments
    send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_coords(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_coords(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_coords(-32768, 0, 32767, 0, 32767, 0, -32768, 0);
    send_coords(-32768, -32768, 0, 0, 32767, 32767, 1, 1);
    send_coords(21845, -21846, -21846, 21845, -21846, -21846, 21845, 21845);
    send_coords(-32768, 32767, 32767, -32768, 0, 0, -1, -1);

    for (int i = 0; i < RAND_PAIRS; i++) begin
      if (i % 250 == 0) begin
        send_idle_pct = $urandom_range(0, 3) * 12;
        recv_idle_pct = $urandom_range(0, 3) * 12;
      end
      if (i >= RAND_PAIRS - 300) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // Back up the pipeline while items keep coming.
      if (i == 600) hold_request = 1'b1;
      send_random_pair();
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
